>>> hdl/bpk_pkg.sv
// ============================================================================
// bpk_pkg
// Shared types and constants for the bit packer: opcodes, controller states,
// and the command/status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package bpk_pkg;

    // Default and upper bound of bits in one push request
    localparam int MAX_PUSH_BITS_DEF = 32;

    // Field widths of the stream channels
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int OPCODE_W = 2;
    localparam int S_DATA_W = 40;
    localparam int BYTE_W   = 8;

    // Byte constants
    localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

    // Request opcodes (code 3 is unused and ignored)
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_ALIGN = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_STUFF
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // take the input request
        logic emit_byte;   // move the top byte of the accumulator to the output
        logic emit_stuff;  // move a stuffing zero byte to the output
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic load_emits;  // the offered request completes at least one byte
        logic emit_more;   // a full byte is waiting in the accumulator
        logic after_more;  // another full byte remains after the current one
        logic ff_stuff;    // current byte is 0xFF and stuffing is on
        logic out_free;    // output register can take a byte this cycle
    } t_dp_status;

endpackage

`default_nettype wire

>>> hdl/bpk_ctrl.sv
// ============================================================================
// bpk_ctrl
// Controller: accepts one request at a time, then sequences the byte and
// stuffing-byte emits through the datapath.
// ============================================================================
`default_nettype none

module bpk_ctrl
    import bpk_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  t_dp_status  i_status,
    output logic        o_s_tready,
    output t_dp_cmd     o_cmd,
    output t_state      o_state
);

    t_state r_state;
    t_state n_state;
    logic   w_fire;

    assign w_fire  = i_s_tvalid && (r_state == ST_IDLE);
    assign o_state = r_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_fire && i_status.load_emits) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    if (i_status.ff_stuff) begin
                        n_state = ST_STUFF;
                    end else if (!i_status.after_more) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_STUFF: begin
                if (i_status.out_free) begin
                    n_state = i_status.emit_more ? ST_EMIT : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = w_fire;
            end
            ST_EMIT:  o_cmd.emit_byte  = i_status.out_free;
            ST_STUFF: o_cmd.emit_stuff = i_status.out_free;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/bpk_datapath.sv
// ============================================================================
// bpk_datapath
// Datapath: bit accumulator with pending count, push/align/clear update,
// byte extraction and the registered output stage.
// ============================================================================
`default_nettype none

module bpk_datapath
    import bpk_pkg::*;
#(
    parameter int MAX_PUSH_BITS = MAX_PUSH_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  wire [OPCODE_W-1:0]  i_opcode,
    input  wire [VALUE_W-1:0]   i_bit_value,
    input  wire [COUNT_W-1:0]   i_bit_count,
    input  wire                 i_stuff_enable,
    input  wire                 i_m_tready,
    output t_dp_status          o_status,
    output logic                o_m_tvalid,
    output logic [BYTE_W-1:0]   o_m_tdata,
    output logic                o_m_tuser,
    output logic                o_m_tlast
);

    localparam int ACC_W = MAX_PUSH_BITS + 7;
    localparam int TOT_W = $clog2(ACC_W + 1);

    // Accumulator: valid bits are the low r_total bits
    logic [ACC_W-1:0]   r_acc,   n_acc;
    logic [TOT_W-1:0]   r_total, n_total;
    logic               r_stuff, n_stuff;

    // Output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_data;
    logic               r_out_user;
    logic               r_out_last;

    logic [COUNT_W-1:0] w_cnt;
    logic [VALUE_W-1:0] w_val_m;
    logic [6:0]         w_pend;
    logic [ACC_W-1:0]   w_push_acc;
    logic [TOT_W-1:0]   w_push_total;
    logic [ACC_W-1:0]   w_align_acc;
    logic [3:0]         w_pad;
    logic [TOT_W-1:0]   w_sh;
    logic [ACC_W-1:0]   w_shifted;
    logic [BYTE_W-1:0]  w_byte;
    logic               w_ff_stuff;
    logic               w_out_free;
    t_opcode            w_op;

    assign w_op = t_opcode'(i_opcode);

    // Clamp the count and drop bits above it
    assign w_cnt   = (i_bit_count > COUNT_W'(MAX_PUSH_BITS)) ?
                     COUNT_W'(MAX_PUSH_BITS) : i_bit_count;
    assign w_val_m = i_bit_value & ~({VALUE_W{1'b1}} << w_cnt);

    // Pending partial byte (only meaningful while fewer than 8 bits remain)
    assign w_pend       = r_acc[6:0] & ~(7'h7f << r_total[2:0]);
    assign w_push_acc   = (ACC_W'(w_pend) << w_cnt) |
                          ACC_W'(w_val_m[MAX_PUSH_BITS-1:0]);
    assign w_push_total = TOT_W'(r_total[2:0]) + TOT_W'(w_cnt);
    assign w_pad        = 4'd8 - {1'b0, r_total[2:0]};
    assign w_align_acc  = ACC_W'(w_pend) << w_pad;

    // Top completed byte
    assign w_sh       = r_total - TOT_W'(8);
    assign w_shifted  = r_acc >> w_sh;
    assign w_byte     = w_shifted[BYTE_W-1:0];
    assign w_ff_stuff = r_stuff && (w_byte == BYTE_FF);
    assign w_out_free = !r_out_valid || i_m_tready;

    // Status to the controller
    always_comb begin
        o_status            = '0;
        o_status.emit_more  = (r_total >= TOT_W'(8));
        o_status.after_more = (w_sh >= TOT_W'(8));
        o_status.ff_stuff   = w_ff_stuff;
        o_status.out_free   = w_out_free;
        unique case (w_op)
            OP_PUSH:  o_status.load_emits = (w_cnt != '0) &&
                                            (w_push_total >= TOT_W'(8));
            OP_ALIGN: o_status.load_emits = (r_total[2:0] != 3'd0);
            default:  o_status.load_emits = 1'b0;
        endcase
    end

    // Accumulator update
    always_comb begin
        n_acc   = r_acc;
        n_total = r_total;
        n_stuff = r_stuff;
        if (i_cmd.load) begin
            unique case (w_op)
                OP_PUSH: begin
                    if (w_cnt != '0) begin
                        n_acc   = w_push_acc;
                        n_total = w_push_total;
                        n_stuff = i_stuff_enable;
                    end
                end
                OP_ALIGN: begin
                    n_acc   = w_align_acc;
                    n_total = (r_total[2:0] != 3'd0) ? TOT_W'(8) : '0;
                    n_stuff = 1'b0;
                end
                OP_CLEAR: n_total = '0;
                default:  n_total = r_total;
            endcase
        end else if (i_cmd.emit_byte) begin
            n_total = w_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_stuff <= 1'b0;
        end else begin
            r_total <= n_total;
            r_stuff <= n_stuff;
        end
        r_acc <= n_acc;
    end

    // Output register: loads on emit, drains on tready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_byte || i_cmd.emit_stuff) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_byte) begin
            r_out_data <= w_byte;
            r_out_user <= 1'b0;
            r_out_last <= !w_ff_stuff && (w_sh < TOT_W'(8));
        end else if (i_cmd.emit_stuff) begin
            r_out_data <= BYTE_ZERO;
            r_out_user <= 1'b1;
            r_out_last <= (r_total < TOT_W'(8));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> hdl/bit_packer_with_ff_stuffing.sv
// ============================================================================
// bit_packer_with_ff_stuffing
// MSB-first bit packer with optional 0xFF/0x00 byte stuffing.
// ============================================================================
// Usage:
//   Slave channel: one request per handshake. tuser carries the opcode
//   (push, align, clear); tdata carries the bits, their count (clamped to
//   MAX_PUSH_BITS) and the stuffing enable.
//   Master channel: one packed byte per handshake; tuser marks an inserted
//   stuffing zero, tlast marks the final byte caused by a request.
//   Requests that complete no byte (short push, clear, align when aligned)
//   produce no output.
// Timing:
//   A request is taken on its handshake; its n output bytes (stuffing
//   included, at most 8) then leave one per cycle through the output
//   register while the receiver does not stall, and the input stays
//   blocked until the last of them is emitted. The controller moves each
//   byte from the accumulator into the output register when it is free.
// Reset / stall:
//   Synchronous active-low reset empties the pending bits and the output
//   register. When the receiver stalls, the current byte holds and the
//   controller waits; the next request is taken once the last byte of the
//   current one is in the output register.
// ============================================================================
`default_nettype none

module bit_packer_with_ff_stuffing
    import bpk_pkg::*;
#(
    parameter int MAX_PUSH_BITS = MAX_PUSH_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Slave side
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    // [31:0] bit_value, [37:32] bit_count, [38] stuff_enable, [39] zero
    input  wire [S_DATA_W-1:0]   i_s_tdata,
    // [1:0] opcode
    input  wire [OPCODE_W-1:0]   i_s_tuser,
    // Master side
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    // [7:0] out_byte
    output logic [BYTE_W-1:0]    o_m_tdata,
    // [0] is_stuffed
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_state     w_state;

    // Controller
    bpk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    // Datapath
    bpk_datapath #(
        .MAX_PUSH_BITS (MAX_PUSH_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_opcode       (i_s_tuser),
        .i_bit_value    (i_s_tdata[31:0]),
        .i_bit_count    (i_s_tdata[37:32]),
        .i_stuff_enable (i_s_tdata[38]),
        .i_m_tready     (i_m_tready),
        .o_status       (w_status),
        .o_m_tvalid     (o_m_tvalid),
        .o_m_tdata      (o_m_tdata),
        .o_m_tuser      (o_m_tuser),
        .o_m_tlast      (o_m_tlast)
    );

    // Stuffing bytes are always zero
    a_stuff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == BYTE_ZERO)
        else $error("stuffing byte is not zero");

    // Back in idle, no full byte is left in the accumulator
    a_idle_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state == ST_IDLE |-> !w_status.emit_more)
        else $error("full byte left pending in idle");

    // A pending stuff is always preceded by an unstuffed 0xFF in the output
    a_stuff_after_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state == ST_STUFF && o_m_tvalid |->
            o_m_tdata == BYTE_FF && !o_m_tuser && !o_m_tlast)
        else $error("stuffing not preceded by 0xFF");

endmodule

`default_nettype wire
